// ----- src/dual_car_hall_call_dispatcher_defines.svh -----
// Assertion macros for the dual-car hall call dispatcher.
`ifndef DUAL_CAR_HALL_CALL_DISPATCHER_DEFINES_SVH
`define DUAL_CAR_HALL_CALL_DISPATCHER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define DCHD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dispatcher check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define DCHD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dispatcher check failed");

`endif

// ----- src/dchd_pkg.sv -----
// Shared types, codes and scoring functions for the hall call dispatcher.
package dchd_pkg;

    localparam int NUM_SLOTS_DEF  = 6;
    localparam int NUM_FLOORS_DEF = 4;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_CLEAR    = 2'd1,
        OP_MARK     = 2'd2,
        OP_RUN      = 2'd3
    } opcode_t;

    localparam logic [1:0] DIR_NO = 2'd0;
    localparam logic [1:0] DIR_UP = 2'd1;
    localparam logic [1:0] DIR_DN = 2'd2;

    localparam logic [1:0] OWN_NONE = 2'd0;
    localparam logic [1:0] OWN_A    = 2'd1;
    localparam logic [1:0] OWN_B    = 2'd2;

    localparam logic [2:0] CAR_IDLE  = 3'd0;
    localparam logic [2:0] CAR_UP    = 3'd1;
    localparam logic [2:0] CAR_DOWN  = 3'd2;
    localparam logic [2:0] CAR_EMERG = 3'd3;

    localparam logic [1:0] PICK_A     = 2'd0;
    localparam logic [1:0] PICK_B     = 2'd1;
    localparam logic [1:0] PICK_DEFER = 2'd2;

    localparam logic [2:0] SCORE_NEAR     = 3'd0;
    localparam logic [2:0] SCORE_PASSED   = 3'd1;
    localparam logic [2:0] SCORE_OPPOSITE = 3'd2;
    localparam logic [2:0] SCORE_NONE     = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_SCAN,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic scan_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic is_run;
        logic cand;
        logic hold_valid;
        logic idx_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [2:0] car_score(input logic [2:0] st, input logic [3:0] cf,
                                             input logic [3:0] f, input logic [1:0] d);
        logic [2:0] s;
        if (st == CAR_IDLE)
            s = SCORE_NEAR;
        else if (st == CAR_UP && d == DIR_UP)
            s = (cf <= f) ? SCORE_NEAR : SCORE_PASSED;
        else if (st == CAR_DOWN && d == DIR_DN)
            s = (cf >= f) ? SCORE_NEAR : SCORE_PASSED;
        else if ((st == CAR_UP && d == DIR_DN) || (st == CAR_DOWN && d == DIR_UP))
            s = SCORE_OPPOSITE;
        else
            s = SCORE_NONE;
        return s;
    endfunction

    function automatic logic [3:0] floor_dist(input logic [3:0] x, input logic [3:0] y);
        return (x >= y) ? (x - y) : (y - x);
    endfunction

    function automatic logic [1:0] choose_car(
        input logic [2:0] as, input logic [3:0] af, input logic bp,
        input logic [2:0] bs, input logic [3:0] bf, input logic ok,
        input logic [3:0] f,  input logic [1:0] d);
        logic [2:0] sa;
        logic [2:0] sb;
        logic [1:0] pick;
        sa = (as == CAR_EMERG) ? SCORE_NONE : car_score(as, af, f, d);
        sb = (!bp || bs == CAR_EMERG) ? SCORE_NONE : car_score(bs, bf, f, d);
        if (!ok)
            pick = (sa == SCORE_NEAR) ? PICK_A : PICK_DEFER;
        else if (as == CAR_IDLE && af == f)
            pick = PICK_A;
        else if (bp && bs == CAR_IDLE && bf == f)
            pick = PICK_B;
        else if (sa != SCORE_NEAR && sb != SCORE_NEAR)
            pick = PICK_DEFER;
        else if (sa < sb)
            pick = PICK_A;
        else if (sb < sa)
            pick = PICK_B;
        else
            pick = (floor_dist(af, f) <= floor_dist(bf, f)) ? PICK_A : PICK_B;
        return pick;
    endfunction

endpackage

// ----- src/dual_car_hall_call_dispatcher.sv -----
// Top level of the dual-car hall call dispatcher.
//
// Input channel (in_valid/in_ready) carries one request word: register, clear
// or mark a hall call, or run a dispatch pass with the current state of both
// cars. Output channel (out_valid/out_ready) returns result words; the final
// word of each request has last set. A run returns one word per assignment in
// slot order, or one empty word when nothing was assigned.
// Sequence: a request is taken in IDLE; register, clear and mark are applied
// in the cycle after, in APPLY, and the final word is loaded into the output
// register in FINISH once that register is free. A run scans one table slot
// per cycle through the shared scoring logic while no receiver stall holds it.
// in_ready is high only between requests; the output register may still hold
// an unread word while the next request is taken.
// Receiver stall: the scan pauses when an assignment must go out and the output
// register is full; nothing is dropped.
// Reset: asynchronous, active low; clears the call table (floor 0, no
// direction, no owner), the sequencer and the output valid.
`include "dual_car_hall_call_dispatcher_defines.svh"

module dual_car_hall_call_dispatcher
    import dchd_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int NUM_FLOORS = NUM_FLOORS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [3:0] floor,
    input  logic [1:0] direction,
    input  logic [1:0] assign_to,
    input  logic [2:0] a_state,
    input  logic [3:0] a_floor,
    input  logic       b_present,
    input  logic [2:0] b_state,
    input  logic [3:0] b_floor,
    input  logic       comm_ok,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       assign_valid,
    output logic       assigned_car,
    output logic [3:0] target_floor,
    output logic [1:0] target_direction,
    output logic [2:0] pending_count,
    output logic       last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    dchd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // table, scoring and output register
    dchd_datapath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .NUM_FLOORS (NUM_FLOORS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .opcode           (opcode),
        .floor            (floor),
        .direction        (direction),
        .assign_to        (assign_to),
        .a_state          (a_state),
        .a_floor          (a_floor),
        .b_present        (b_present),
        .b_state          (b_state),
        .b_floor          (b_floor),
        .comm_ok          (comm_ok),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .assign_valid     (assign_valid),
        .assigned_car     (assigned_car),
        .target_floor     (target_floor),
        .target_direction (target_direction),
        .pending_count    (pending_count),
        .last             (last)
    );

    // one request at a time: ready drops right after an accept
    `DCHD_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
    // an empty word is always the final word of its request
    `DCHD_ASSERT_IMPL(a_empty_is_last, out_valid && !assign_valid, last)
    // an assignment names a real stored call
    `DCHD_ASSERT_IMPL(a_assign_real, out_valid && assign_valid, target_floor != 4'd0 && (target_direction == DIR_UP || target_direction == DIR_DN))

endmodule

// ----- src/dchd_ctrl.sv -----
// Sequencer: accept, apply or scan, then deliver the final word.
module dchd_ctrl
    import dchd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        stall;

    // scan must wait when a held word needs the output register and it is full
    assign stall = status.cand && status.hold_valid && !status.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_APPLY;
            S_APPLY:
                state_next = status.is_run ? S_SCAN : S_FINISH;
            S_SCAN:
                if (!stall && status.idx_last)
                    state_next = S_FINISH;
            S_FINISH:
                if (status.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_APPLY:
                cmd.apply = !status.is_run;
            S_SCAN:
                cmd.scan_step = !stall;
            S_FINISH:
                cmd.finish = status.out_free;
            default:
                cmd = '0;
        endcase
    end

endmodule

// ----- src/dchd_datapath.sv -----
// Call table, captured request, scan index, held result and output register.
module dchd_datapath
    import dchd_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int NUM_FLOORS = NUM_FLOORS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    input  logic [1:0] opcode,
    input  logic [3:0] floor,
    input  logic [1:0] direction,
    input  logic [1:0] assign_to,
    input  logic [2:0] a_state,
    input  logic [3:0] a_floor,
    input  logic       b_present,
    input  logic [2:0] b_state,
    input  logic [3:0] b_floor,
    input  logic       comm_ok,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       assign_valid,
    output logic       assigned_car,
    output logic [3:0] target_floor,
    output logic [1:0] target_direction,
    output logic [2:0] pending_count,
    output logic       last
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam logic [3:0]       FLOOR_MAX = 4'(NUM_FLOORS);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_SLOTS - 1);

    // captured word
    opcode_t    op_reg;
    logic [3:0] floor_reg;
    logic [1:0] dir_reg;
    logic [1:0] own_reg;
    logic [2:0] a_state_reg;
    logic [3:0] a_floor_reg;
    logic       b_present_reg;
    logic [2:0] b_state_reg;
    logic [3:0] b_floor_reg;
    logic       comm_ok_reg;

    // call table
    logic [3:0] tab_floor_reg [NUM_SLOTS];
    logic [1:0] tab_dir_reg   [NUM_SLOTS];
    logic [1:0] tab_owner_reg [NUM_SLOTS];
    logic [3:0] tab_floor_next [NUM_SLOTS];
    logic [1:0] tab_dir_next   [NUM_SLOTS];
    logic [1:0] tab_owner_next [NUM_SLOTS];

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    // one assignment held back until we know whether it is the last
    logic       hold_valid_reg;
    logic       hold_valid_next;
    logic       hold_car_reg;
    logic [3:0] hold_floor_reg;
    logic [1:0] hold_dir_reg;
    logic [2:0] hold_pend_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic       assign_valid_reg;
    logic       assigned_car_reg;
    logic [3:0] target_floor_reg;
    logic [1:0] target_direction_reg;
    logic [2:0] pending_count_reg;
    logic       last_reg;

    logic [CNT_W-1:0] pend_now;
    logic [IDX_W-1:0] match_idx;
    logic             match_found;
    logic [IDX_W-1:0] free_idx;
    logic             free_found;
    logic             call_ok;
    logic [3:0]       cur_floor;
    logic [1:0]       cur_dir;
    logic [1:0]       cur_owner;
    logic [1:0]       pick;
    logic             cand;
    logic             out_free;
    logic             push_mid;
    logic             load_hold;

    always_comb
    begin
        pend_now = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (tab_floor_reg[i] != 4'd0 && tab_owner_reg[i] == OWN_NONE)
                pend_now = pend_now + CNT_W'(1);
    end

    // lowest matching slot and lowest free slot
    always_comb
    begin
        match_idx   = '0;
        match_found = 1'b0;
        free_idx    = '0;
        free_found  = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (tab_floor_reg[i] == floor_reg && tab_dir_reg[i] == dir_reg)
            begin
                match_idx   = IDX_W'(i);
                match_found = 1'b1;
            end
            if (tab_floor_reg[i] == 4'd0)
            begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (floor_reg < 4'd1 || floor_reg > FLOOR_MAX)
            call_ok = 1'b0;
        else if (floor_reg == 4'd1)
            call_ok = (dir_reg == DIR_UP);
        else if (floor_reg == FLOOR_MAX)
            call_ok = (dir_reg == DIR_DN);
        else
            call_ok = (dir_reg == DIR_UP) || (dir_reg == DIR_DN);
    end

    assign cur_floor = tab_floor_reg[idx_reg];
    assign cur_dir   = tab_dir_reg[idx_reg];
    assign cur_owner = tab_owner_reg[idx_reg];
    assign pick      = choose_car(a_state_reg, a_floor_reg, b_present_reg, b_state_reg,
                                  b_floor_reg, comm_ok_reg, cur_floor, cur_dir);
    assign cand      = (cur_floor != 4'd0) && (cur_owner == OWN_NONE) && (pick != PICK_DEFER);

    assign out_free  = !out_valid_reg || out_ready;
    assign load_hold = cmd.scan_step && cand;
    assign push_mid  = load_hold && hold_valid_reg;

    always_comb
    begin
        status.is_run     = (op_reg == OP_RUN);
        status.cand       = cand;
        status.hold_valid = hold_valid_reg;
        status.idx_last   = (idx_reg == IDX_LAST);
        status.out_free   = out_free;
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tab_floor_next[i] = tab_floor_reg[i];
            tab_dir_next[i]   = tab_dir_reg[i];
            tab_owner_next[i] = tab_owner_reg[i];
        end
        if (cmd.apply)
        begin
            unique case (op_reg)
                OP_REGISTER:
                    if (call_ok)
                    begin
                        if (match_found)
                            tab_owner_next[match_idx] = OWN_NONE;
                        else if (free_found)
                        begin
                            tab_floor_next[free_idx] = floor_reg;
                            tab_dir_next[free_idx]   = dir_reg;
                            tab_owner_next[free_idx] = OWN_NONE;
                        end
                    end
                OP_CLEAR:
                    if (match_found)
                    begin
                        tab_floor_next[match_idx] = 4'd0;
                        tab_dir_next[match_idx]   = DIR_NO;
                        tab_owner_next[match_idx] = OWN_NONE;
                    end
                OP_MARK:
                    if (match_found && own_reg <= OWN_B)
                        tab_owner_next[match_idx] = own_reg;
                OP_RUN:
                    tab_owner_next[match_idx] = tab_owner_reg[match_idx];
                default:
                    tab_owner_next[match_idx] = tab_owner_reg[match_idx];
            endcase
        end
        if (load_hold)
            tab_owner_next[idx_reg] = (pick == PICK_A) ? OWN_A : OWN_B;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.capture)
            idx_next = '0;
        else if (cmd.scan_step && idx_reg != IDX_LAST)
            idx_next = idx_reg + IDX_W'(1);
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (cmd.capture || cmd.finish)
            hold_valid_next = 1'b0;
        else if (load_hold)
            hold_valid_next = 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push_mid || cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                tab_floor_reg[i] <= 4'd0;
                tab_dir_reg[i]   <= DIR_NO;
                tab_owner_reg[i] <= OWN_NONE;
            end
            idx_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                tab_floor_reg[i] <= tab_floor_next[i];
                tab_dir_reg[i]   <= tab_dir_next[i];
                tab_owner_reg[i] <= tab_owner_next[i];
            end
            idx_reg        <= idx_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= opcode_t'(opcode);
            floor_reg     <= floor;
            dir_reg       <= direction;
            own_reg       <= assign_to;
            a_state_reg   <= a_state;
            a_floor_reg   <= a_floor;
            b_present_reg <= b_present;
            b_state_reg   <= b_state;
            b_floor_reg   <= b_floor;
            comm_ok_reg   <= comm_ok;
        end
        if (load_hold)
        begin
            hold_car_reg   <= (pick == PICK_B);
            hold_floor_reg <= cur_floor;
            hold_dir_reg   <= cur_dir;
            hold_pend_reg  <= 3'(pend_now - CNT_W'(1));
        end
        if (push_mid)
        begin
            assign_valid_reg     <= 1'b1;
            assigned_car_reg     <= hold_car_reg;
            target_floor_reg     <= hold_floor_reg;
            target_direction_reg <= hold_dir_reg;
            pending_count_reg    <= hold_pend_reg;
            last_reg             <= 1'b0;
        end
        else if (cmd.finish)
        begin
            last_reg <= 1'b1;
            if (hold_valid_reg)
            begin
                assign_valid_reg     <= 1'b1;
                assigned_car_reg     <= hold_car_reg;
                target_floor_reg     <= hold_floor_reg;
                target_direction_reg <= hold_dir_reg;
                pending_count_reg    <= hold_pend_reg;
            end
            else
            begin
                assign_valid_reg     <= 1'b0;
                assigned_car_reg     <= 1'b0;
                target_floor_reg     <= 4'd0;
                target_direction_reg <= DIR_NO;
                pending_count_reg    <= 3'(pend_now);
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign assign_valid     = assign_valid_reg;
    assign assigned_car     = assigned_car_reg;
    assign target_floor     = target_floor_reg;
    assign target_direction = target_direction_reg;
    assign pending_count    = pending_count_reg;
    assign last             = last_reg;

endmodule
